### src/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared constants, codes and control/status types for the periodic timer
// table.
// ----------------------------------------------------------------------------
package ptt_pkg;

    // Table geometry
    localparam int NUM_TIMERS = 16;
    localparam int IDX_W      = $clog2(NUM_TIMERS);

    // Field widths
    localparam int CMD_W   = 2;
    localparam int ID_W    = 4;
    localparam int PER_W   = 16;
    localparam int TIME_W  = 32;
    localparam int KIND_W  = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_OK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic             wr_add;    // arm slot timer_id with now + interval
        logic             wr_del;    // free slot timer_id
        logic             load_now;  // capture now for a tick scan
        logic             scan_en;   // examine slot scan_idx this cycle
        logic [IDX_W-1:0] scan_idx;
    } ptt_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic add_ok;    // add command is legal (nonzero period, id in range)
        logic slot_hit;  // slot scan_idx is armed and due
    } ptt_stat_t;

endpackage

### src/periodic_timer_table_top.sv
// ----------------------------------------------------------------------------
// periodic_timer_table_top
// Bank of periodic timers, one slot per id, with add, delete and tick.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Add and delete
// each give one result, strobed on done in the cycle after the transaction,
// and the block takes the next transaction in that same cycle (one per
// cycle). A tick holds busy while the slots are walked one per cycle
// through the single due-check and deadline-advance unit, and then while a
// flush state closes the scan. Fired ids come out in ascending order. Each one
// is held until the next due slot is found or the scan closes, so that the
// final one can carry last; that final result appears in the cycle in which
// busy falls, when the next transaction may already be taken. A tick
// with nothing due gives no result. done is a one-cycle strobe and the
// receiver cannot stall it: results must be captured as they appear.
// ----------------------------------------------------------------------------
module periodic_timer_table_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ptt_pkg::CMD_W-1:0]   cmd,
    input  logic [ptt_pkg::ID_W-1:0]    timer_id,
    input  logic [ptt_pkg::PER_W-1:0]   interval,
    input  logic [ptt_pkg::TIME_W-1:0]  now,
    output logic                        done,
    output logic [ptt_pkg::KIND_W-1:0]  kind,
    output logic [ptt_pkg::ID_W-1:0]    timer_id_res,
    output logic                        last
);
    import ptt_pkg::*;

    ptt_cmd_t         ctl;
    ptt_stat_t        stat;
    logic [IDX_W-1:0] res_idx;

    logic [ID_W-1:0]  add_del_id_reg;

    // Sequencer
    ptt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .stat    (stat),
        .ctl     (ctl),
        .busy    (busy),
        .done    (done),
        .kind    (kind),
        .res_idx (res_idx),
        .last    (last)
    );

    // Slot storage
    ptt_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .timer_id (timer_id),
        .interval (interval),
        .now      (now),
        .ctl      (ctl),
        .stat     (stat)
    );

    // Id for add/delete results is the raw field, registered when the transaction is taken
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            add_del_id_reg <= timer_id;
        end
    end

    assign timer_id_res = (kind == KIND_FIRED) ? ID_W'(res_idx) : add_del_id_reg;

endmodule

### src/ptt_dpath.sv
// ----------------------------------------------------------------------------
// ptt_dpath
// Timer slot storage: armed flags, periods and deadlines, with the due check
// and deadline advance for the slot under scan.
// ----------------------------------------------------------------------------
module ptt_dpath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [ptt_pkg::ID_W-1:0]  timer_id,
    input  logic [ptt_pkg::PER_W-1:0] interval,
    input  logic [ptt_pkg::TIME_W-1:0] now,
    input  ptt_pkg::ptt_cmd_t         ctl,
    output ptt_pkg::ptt_stat_t        stat
);
    import ptt_pkg::*;

    logic [NUM_TIMERS-1:0] armed_reg;
    logic [PER_W-1:0]      period_reg   [NUM_TIMERS];
    logic [TIME_W-1:0]     deadline_reg [NUM_TIMERS];
    logic [TIME_W-1:0]     now_reg;

    logic [IDX_W-1:0]      wr_idx;
    logic                  id_in_range;
    logic [TIME_W-1:0]     scan_deadline;
    logic [PER_W-1:0]      scan_period;

    // Addressing and status
    assign wr_idx        = IDX_W'(timer_id);
    assign id_in_range   = (32'(timer_id) < NUM_TIMERS);
    assign scan_deadline = deadline_reg[ctl.scan_idx];
    assign scan_period   = period_reg[ctl.scan_idx];

    assign stat.add_ok   = (interval != '0) && id_in_range;
    assign stat.slot_hit = armed_reg[ctl.scan_idx] && (scan_deadline <= now_reg);

    // Armed flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= '0;
        end
        else if (ctl.wr_add)
        begin
            armed_reg[wr_idx] <= 1'b1;
        end
        else if (ctl.wr_del && id_in_range)
        begin
            armed_reg[wr_idx] <= 1'b0;
        end
    end

    // Period, deadline and tick time storage
    always_ff @(posedge clk)
    begin
        if (ctl.load_now)
        begin
            now_reg <= now;
        end
        if (ctl.wr_add)
        begin
            period_reg[wr_idx]   <= interval;
            deadline_reg[wr_idx] <= now + TIME_W'(interval);
        end
        else if (ctl.scan_en && stat.slot_hit)
        begin
            deadline_reg[ctl.scan_idx] <= scan_deadline + TIME_W'(scan_period);
        end
    end

endmodule

### src/ptt_ctrl.sv
// ----------------------------------------------------------------------------
// ptt_ctrl
// Command sequencer: decodes commands, walks the slots on a tick and drives
// the result strobe, holding each fired id back one step to mark the last.
// ----------------------------------------------------------------------------
module ptt_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ptt_pkg::CMD_W-1:0]  cmd,
    input  ptt_pkg::ptt_stat_t         stat,
    output ptt_pkg::ptt_cmd_t          ctl,
    output logic                       busy,
    output logic                       done,
    output logic [ptt_pkg::KIND_W-1:0] kind,
    output logic [ptt_pkg::IDX_W-1:0]  res_idx,
    output logic                       last
);
    import ptt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t            state_reg,    state_next;
    logic [IDX_W-1:0]  idx_reg,      idx_next;
    logic              pend_reg,     pend_next;
    logic [IDX_W-1:0]  pend_id_reg,  pend_id_next;
    logic              done_reg,     done_next;
    logic [KIND_W-1:0] kind_reg,     kind_next;
    logic [IDX_W-1:0]  res_idx_reg,  res_idx_next;
    logic              last_reg,     last_next;
    logic              accept;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign done    = done_reg;
    assign kind    = kind_reg;
    assign res_idx = res_idx_reg;
    assign last    = last_reg;

    // Next state, datapath commands and result selection
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        pend_next    = pend_reg;
        pend_id_next = pend_id_reg;
        done_next    = 1'b0;
        kind_next    = kind_reg;
        res_idx_next = res_idx_reg;
        last_next    = last_reg;

        ctl.wr_add   = 1'b0;
        ctl.wr_del   = 1'b0;
        ctl.load_now = 1'b0;
        ctl.scan_en  = 1'b0;
        ctl.scan_idx = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_ADD:
                        begin
                            ctl.wr_add = stat.add_ok;
                            done_next  = 1'b1;
                            kind_next  = stat.add_ok ? KIND_OK : KIND_REJECT;
                            last_next  = 1'b1;
                        end
                        CMD_DEL:
                        begin
                            ctl.wr_del = 1'b1;
                            done_next  = 1'b1;
                            kind_next  = KIND_OK;
                            last_next  = 1'b1;
                        end
                        CMD_TICK:
                        begin
                            ctl.load_now = 1'b1;
                            idx_next     = '0;
                            pend_next    = 1'b0;
                            state_next   = ST_SCAN;
                        end
                        default:
                        begin
                            // unused code: no effect, no result
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                ctl.scan_en = 1'b1;
                if (stat.slot_hit)
                begin
                    // previous hit is now known not to be the last one
                    if (pend_reg)
                    begin
                        done_next    = 1'b1;
                        kind_next    = KIND_FIRED;
                        res_idx_next = pend_id_reg;
                        last_next    = 1'b0;
                    end
                    pend_next    = 1'b1;
                    pend_id_next = idx_reg;
                end
                if (32'(idx_reg) == NUM_TIMERS - 1)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (pend_reg)
                begin
                    done_next    = 1'b1;
                    kind_next    = KIND_FIRED;
                    res_idx_next = pend_id_reg;
                    last_next    = 1'b1;
                end
                pend_next  = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            pend_id_reg <= '0;
            done_reg    <= 1'b0;
            kind_reg    <= KIND_OK;
            res_idx_reg <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            pend_id_reg <= pend_id_next;
            done_reg    <= done_next;
            kind_reg    <= kind_next;
            res_idx_reg <= res_idx_next;
            last_reg    <= last_next;
        end
    end

endmodule

### tb/tb_periodic_timer_table_top.sv
// ----------------------------------------------------------------------------
// tb_periodic_timer_table_top
// Self-checking testbench for the periodic timer table. A directed table
// covers reset state, rejects, overwrite, free-slot delete, the unused
// command code and time extremes. Randomized add/delete/tick traffic with
// monotonic time and full-table bursts follows. Every result is compared
// against an in-bench model of the timer bank or a directed row's own kind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_periodic_timer_table_top;

    import ptt_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;
    localparam int               N_DIR          = 21;
    localparam int               N_RANDOM       = 330;
    localparam int               WATCHDOG_LIMIT = 2000;
    localparam int               DRAIN_CYCLES   = NUM_TIMERS + 8;
    localparam int               EXP_AW         = 6;
    localparam int               EXP_DEPTH      = 1 << EXP_AW;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic              last;
    } timer_result_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   id;
        logic [PER_W-1:0]  ival;
        logic [TIME_W-1:0] tnow;
        logic              typed;   // expected result written in the row
        logic [KIND_W-1:0] kind;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [CMD_W-1:0]    cmd;
    logic [ID_W-1:0]     timer_id;
    logic [PER_W-1:0]    interval;
    logic [TIME_W-1:0]   now;
    logic                done;
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     timer_id_res;
    logic                last;

    // Model of the timer bank
    logic                model_armed    [NUM_TIMERS];
    logic [PER_W-1:0]    model_period   [NUM_TIMERS];
    logic [TIME_W-1:0]   model_deadline [NUM_TIMERS];

    // Expected results, in order: written by the stimulus, read by the checker
    timer_result_t       exp_mem [EXP_DEPTH];
    int                  exp_wr = 0;
    int                  exp_rd = 0;

    dir_row_t            dir_rows [0:N_DIR-1];
    int                  err_count = 0;
    int                  idle_cycles = 0;
    int                  gap_max;
    int                  items_sent;

    periodic_timer_table_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .timer_id     (timer_id),
        .interval     (interval),
        .now          (now),
        .done         (done),
        .kind         (kind),
        .timer_id_res (timer_id_res),
        .last         (last)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Append one expected result
    task automatic exp_put(input timer_result_t r);
        exp_mem[EXP_AW'(exp_wr)] = r;
        exp_wr++;
    endtask

    // Apply one command to the bank model, queueing the results it causes
    task automatic timer_bank_step(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] id,
                                   input logic [PER_W-1:0] ival,
                                   input logic [TIME_W-1:0] tnow);
        int n_fired;
        n_fired = 0;
        case (c)
            CMD_ADD:
            begin
                if (ival == '0 || int'(id) >= NUM_TIMERS)
                    exp_put(timer_result_t'{KIND_REJECT, id, 1'b1});
                else
                begin
                    model_armed[id]    = 1'b1;
                    model_period[id]   = ival;
                    model_deadline[id] = tnow + TIME_W'(ival);
                    exp_put(timer_result_t'{KIND_OK, id, 1'b1});
                end
            end
            CMD_DEL:
            begin
                if (int'(id) < NUM_TIMERS)
                    model_armed[id] = 1'b0;
                exp_put(timer_result_t'{KIND_OK, id, 1'b1});
            end
            CMD_TICK:
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (model_armed[i] && model_deadline[i] <= tnow)
                    begin
                        model_deadline[i] = model_deadline[i] + TIME_W'(model_period[i]);
                        exp_put(timer_result_t'{KIND_FIRED, ID_W'(i), 1'b0});
                        n_fired++;
                    end
                end
                if (n_fired > 0)
                    exp_mem[EXP_AW'(exp_wr - 1)].last = 1'b1;
            end
            default: ;  // unused code: no result, no state change
        endcase
    endtask

    // Issue one transaction after a random gap; predict once it is taken
    task automatic send_command(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] id,
                                input logic [PER_W-1:0] ival,
                                input logic [TIME_W-1:0] tnow,
                                input logic typed, input logic [KIND_W-1:0] typed_kind);
        int gap;
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd      <= c;
        timer_id <= id;
        interval <= ival;
        now      <= tnow;
        start    <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        timer_bank_step(c, id, ival, tnow);
        // typed rows are single-result commands; the row value replaces the model's
        if (typed)
            exp_mem[EXP_AW'(exp_wr - 1)] = timer_result_t'{typed_kind, id, 1'b1};
        items_sent++;
    endtask

    // Hold off new commands until every outstanding result has arrived
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge clk);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        timer_result_t exp_res;
        if (rst_n && done)
        begin
            if (exp_wr == exp_rd)
            begin
                $display("%0t: unexpected result kind=%0d id=%0d last=%0d",
                         $time, kind, timer_id_res, last);
                err_count++;
            end
            else
            begin
                exp_res = exp_mem[EXP_AW'(exp_rd)];
                exp_rd++;
                if (kind !== exp_res.kind)
                begin
                    $display("%0t: kind mismatch: expected %0d, actual %0d",
                             $time, exp_res.kind, kind);
                    err_count++;
                end
                if (timer_id_res !== exp_res.id)
                begin
                    $display("%0t: timer_id_res mismatch: expected %0d, actual %0d",
                             $time, exp_res.id, timer_id_res);
                    err_count++;
                end
                if (last !== exp_res.last)
                begin
                    $display("%0t: last mismatch: expected %0d, actual %0d",
                             $time, exp_res.last, last);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: cycles with neither a transaction nor a result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("periodic_timer_table_top regression: fail");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        logic [TIME_W-1:0] cur_time;
        logic [PER_W-1:0]  ival;
        logic [CMD_W-1:0]  c;
        int                pick;

        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = CMD_TICK;
        timer_id    = '0;
        interval    = '0;
        now         = '0;
        items_sent  = 0;
        gap_max     = 16;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            model_armed[i]    = 1'b0;
            model_period[i]   = '0;
            model_deadline[i] = '0;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // cmd, id, interval, now, typed, kind
        dir_rows = '{
            '{CMD_TICK,   4'd0,  16'd0,      32'd0,          1'b0, KIND_OK},     // nothing armed
            '{CMD_DEL,    4'd0,  16'd0,      32'd0,          1'b1, KIND_OK},     // free slot
            '{CMD_ADD,    4'd0,  16'd0,      32'd5,          1'b1, KIND_REJECT}, // zero period
            '{CMD_ADD,    4'd15, 16'hFFFF,   32'd0,          1'b1, KIND_OK},
            '{CMD_ADD,    4'd0,  16'd1,      32'd0,          1'b1, KIND_OK},
            '{CMD_TICK,   4'd0,  16'd0,      32'd0,          1'b0, KIND_OK},     // not yet due
            '{CMD_TICK,   4'd0,  16'd0,      32'd1,          1'b0, KIND_OK},     // due exactly
            '{CMD_ADD,    4'd7,  16'd5,      32'd100,        1'b1, KIND_OK},
            '{CMD_ADD,    4'd3,  16'd10,     32'd10,         1'b1, KIND_OK},
            '{CMD_ADD,    4'd3,  16'd20,     32'd0,          1'b1, KIND_OK},     // overwrite
            '{CMD_TICK,   4'd0,  16'd0,      32'd200,        1'b0, KIND_OK},
            '{CMD_TICK,   4'd0,  16'd0,      32'd200,        1'b0, KIND_OK},     // catch-up
            '{CMD_DEL,    4'd7,  16'd0,      32'd0,          1'b1, KIND_OK},
            '{CMD_DEL,    4'd7,  16'hFFFF,   32'hFFFFFFFF,   1'b1, KIND_OK},     // already free
            '{CMD_UNUSED, 4'd5,  16'h1234,   32'hFFFFFFFF,   1'b0, KIND_OK},     // ignored
            '{CMD_TICK,   4'd0,  16'd0,      32'd65535,      1'b0, KIND_OK},
            '{CMD_ADD,    4'd8,  16'hFFFF,   32'hFFFF0000,   1'b1, KIND_OK},     // max deadline
            '{CMD_TICK,   4'd0,  16'd0,      32'hFFFFFFFE,   1'b0, KIND_OK},
            '{CMD_DEL,    4'd8,  16'd0,      32'd0,          1'b1, KIND_OK},
            '{CMD_TICK,   4'd0,  16'd0,      32'hFFFFFFFF,   1'b0, KIND_OK},     // max time
            '{CMD_ADD,    4'd12, 16'd0,      32'hFFFFFFFF,   1'b1, KIND_REJECT}
        };

        // Directed table
        for (int r = 0; r < N_DIR; r++)
            send_command(dir_rows[r].cmd, dir_rows[r].id, dir_rows[r].ival, dir_rows[r].tnow,
                         dir_rows[r].typed, dir_rows[r].kind);
        wait_drained();

        // Random traffic with monotonic time
        cur_time = TIME_W'($urandom_range(0, 1 << 20));
        items_sent = 0;
        while (items_sent < N_RANDOM)
        begin
            if (items_sent % 40 == 0)
                gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
            if (items_sent >= 160 && items_sent < 165)
                wait_drained();

            pick = $urandom_range(0, 99);
            if (items_sent == 0 || pick < 4)
            begin
                // arm every slot, then one tick where all are due
                for (int i = 0; i < NUM_TIMERS; i++)
                    send_command(CMD_ADD, ID_W'(i), PER_W'($urandom_range(1, 2000)),
                                 cur_time, 1'b0, KIND_OK);
                cur_time = cur_time + 2001;
                send_command(CMD_TICK, ID_W'($urandom), PER_W'($urandom), cur_time,
                             1'b0, KIND_OK);
            end
            else if (pick < 42)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    ival = PER_W'($urandom_range(1, 64));
                else if (pick < 88)
                    ival = PER_W'($urandom);
                else
                    ival = '0;
                send_command(CMD_ADD, ID_W'($urandom), ival, cur_time, 1'b0, KIND_OK);
            end
            else if (pick < 57)
                send_command(CMD_DEL, ID_W'($urandom), PER_W'($urandom), $urandom,
                             1'b0, KIND_OK);
            else if (pick < 95)
            begin
                if ($urandom_range(0, 9) == 0)
                    cur_time = cur_time + TIME_W'($urandom_range(0, 70000));
                else
                    cur_time = cur_time + TIME_W'($urandom_range(0, 80));
                send_command(CMD_TICK, ID_W'($urandom), PER_W'($urandom), cur_time,
                             1'b0, KIND_OK);
            end
            else
            begin
                c = CMD_UNUSED;
                send_command(c, ID_W'($urandom), PER_W'($urandom), $urandom, 1'b0, KIND_OK);
            end
        end

        // Drain and let the last scan close
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0 && exp_wr == exp_rd)
            $display("periodic_timer_table_top regression: pass");
        else
            $display("periodic_timer_table_top regression: fail");
        $finish;
    end

endmodule
